FILE: rtl/bda_pkg.sv
// Shared types, constants and the digit-extraction function for the
// binary to decimal ASCII converter. No dependencies.
package bda_pkg;

	localparam int unsigned NUM_DIGITS = 5;

	// Position of the units digit; digits are ordered most significant first.
	localparam logic [2:0] LAST_POS = 3'd4;

	localparam logic [5:0] ZERO_CHAR = 6'd48;

	localparam logic [13:0] W_10000 = 14'd10000;
	localparam logic [13:0] W_1000  = 14'd1000;
	localparam logic [13:0] W_100   = 14'd100;
	localparam logic [13:0] W_10    = 14'd10;

	typedef logic [3:0] digit_t;

	// One converted number: digit 0 is ten-thousands, digit 4 is units.
	typedef struct packed {
		digit_t [NUM_DIGITS-1:0] digits;
		logic [2:0]              start;
	} bda_num_t;

	typedef struct packed {
		digit_t      digit;
		logic [15:0] rest;
	} bda_step_t;

	// Quotient (known to be below ten) and remainder of rest by weight.
	// The nine multiples are compared side by side; weight is a constant.
	function automatic bda_step_t digit_step(input logic [15:0] rest,
			input logic [13:0] weight);
		bda_step_t   r;
		logic [19:0] m;
		logic [19:0] sub;
		digit_t      d;
		d   = '0;
		sub = '0;
		for (int k = 1; k < 10; k++) begin
			m = 20'(k) * {6'd0, weight};
			if ({4'd0, rest} >= m) begin
				d   = 4'(k);
				sub = m;
			end
		end
		r.digit = d;
		r.rest  = 16'({4'd0, rest} - sub);
		return r;
	endfunction

endpackage

FILE: rtl/bda_conv_pipe.sv
// Four-stage conversion pipeline: one decimal digit per stage, tens and
// units in the last. Depends on bda_pkg.
module bda_conv_pipe (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        value,
	output logic               num_valid,
	input  logic               num_ready,
	output bda_pkg::bda_num_t  num
);

	logic                   v_s1, v_s2, v_s3, v_s4;
	logic                   rdy1, rdy2, rdy3, rdy4;
	bda_pkg::digit_t        dig_s1;
	logic [13:0]            rest_s1;
	bda_pkg::digit_t [1:0]  dig_s2;
	logic [9:0]             rest_s2;
	bda_pkg::digit_t [2:0]  dig_s3;
	logic [6:0]             rest_s3;
	bda_pkg::bda_num_t      num_s4;
	bda_pkg::bda_step_t     st1, st2, st3, st4;
	bda_pkg::bda_num_t      num_next;

	// A stage moves when it is empty or the next one moves.
	assign rdy4     = !v_s4 || num_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign st1 = bda_pkg::digit_step(value, bda_pkg::W_10000);
	assign st2 = bda_pkg::digit_step({2'd0, rest_s1}, bda_pkg::W_1000);
	assign st3 = bda_pkg::digit_step({6'd0, rest_s2}, bda_pkg::W_100);
	assign st4 = bda_pkg::digit_step({9'd0, rest_s3}, bda_pkg::W_10);

	always_comb begin
		num_next.digits[0] = dig_s3[0];
		num_next.digits[1] = dig_s3[1];
		num_next.digits[2] = dig_s3[2];
		num_next.digits[3] = st4.digit;
		num_next.digits[4] = st4.rest[3:0];
		// First nonzero digit; units always shown.
		num_next.start = bda_pkg::LAST_POS;
		for (int i = 3; i >= 0; i--) begin
			if (num_next.digits[i] != '0) begin
				num_next.start = 3'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			dig_s1  <= st1.digit;
			rest_s1 <= st1.rest[13:0];
		end
		if (rdy2 && v_s1) begin
			dig_s2[0] <= dig_s1;
			dig_s2[1] <= st2.digit;
			rest_s2   <= st2.rest[9:0];
		end
		if (rdy3 && v_s2) begin
			dig_s3[0] <= dig_s2[0];
			dig_s3[1] <= dig_s2[1];
			dig_s3[2] <= st3.digit;
			rest_s3   <= st3.rest[6:0];
		end
		if (rdy4 && v_s3) begin
			num_s4 <= num_next;
		end
	end

	assign num_valid = v_s4;
	assign num       = num_s4;

`ifndef SYNTHESIS
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !num_ready |=> v_s4 && $stable(num_s4))
		else $error("stalled stage 4 lost or changed its number");

	a_s1_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> dig_s1 <= 4'd6)
		else $error("ten-thousands digit out of range");

	a_s2_rest: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> rest_s2 < 10'd1000)
		else $error("remainder after thousands digit too large");
`endif

endmodule

FILE: rtl/bda_serializer.sv
// Holds one converted number and sends its digits as ASCII characters,
// one per transaction, skipping leading zeros. Depends on bda_pkg.
module bda_serializer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               num_valid,
	output logic               num_ready,
	input  bda_pkg::bda_num_t  num,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [5:0]         digit_char,
	output logic               last_digit
);

	logic                                     busy_q;
	logic [2:0]                               pos_q;
	bda_pkg::digit_t [bda_pkg::NUM_DIGITS-1:0] digits_q;
	logic                                     at_last;
	logic                                     take;

	assign at_last   = (pos_q == bda_pkg::LAST_POS);
	// Reload in the same cycle the final character leaves.
	assign num_ready = !busy_q || (out_ready && at_last);
	assign take      = num_valid && num_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			pos_q  <= num.start;
		end else if (busy_q && out_ready) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			digits_q <= num.digits;
		end
	end

	assign out_valid  = busy_q;
	assign digit_char = bda_pkg::ZERO_CHAR | {2'b00, digits_q[pos_q]};
	assign last_digit = at_last;

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pos_q <= bda_pkg::LAST_POS)
		else $error("digit position past units");

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_digit |=> out_valid)
		else $error("number ended before its units digit");

	a_no_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (digit_char != bda_pkg::ZERO_CHAR) || last_digit)
		else $error("leading zero sent");
`endif

endmodule

FILE: rtl/binary_to_decimal_ascii.sv
// Top level of the 16-bit binary to decimal ASCII converter.
// Depends on bda_pkg, bda_conv_pipe and bda_serializer.
//
//   channel  signals                      payload
//   -------  ---------------------------  ---------------------------------
//   input    in_valid / in_ready          value[15:0], unsigned binary
//   output   out_valid / out_ready        digit_char[5:0], last_digit
//
// A value enters in any cycle the four-stage digit pipeline has room.
// The first character passes through the four digit stages, then the
// character register. Each value then occupies the output for 1 to 5
// characters, so the character register sets the sustained rate: it takes
// a new value only when idle or as the final character of the held one leaves.
// Reset clears the valid flags and the character position; data registers
// are left as they are.
// Back-pressure on out_ready stalls the pipeline stage by stage, holding
// every transaction in place without loss or repeat.
module binary_to_decimal_ascii (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  digit_char,
	output logic        last_digit
);

	// Hand-off between the digit pipeline and the character register.
	logic              num_valid;
	logic              num_ready;
	bda_pkg::bda_num_t num;

	// Stages 1..4: ten-thousands, thousands, hundreds, then tens and units
	// together with the position of the first significant digit.
	bda_conv_pipe u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.num_valid (num_valid),
		.num_ready (num_ready),
		.num       (num)
	);

	// Character register: walks the held number from its first significant
	// digit to the units digit, flagging the units digit as last.
	bda_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.num_valid  (num_valid),
		.num_ready  (num_ready),
		.num        (num),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digit_char (digit_char),
		.last_digit (last_digit)
	);

endmodule
